// ===== hw/rtl/obrb_pkg.sv =====
package obrb_pkg;

    // Default number of byte slots in the store
    localparam int STORE_DEPTH_DEF = 4096;
    // Size register value after reset, before clamping to the store depth
    localparam int SIZE_RST_DEF    = 4096;

    localparam int OPC_W  = 3;
    localparam int BYTE_W = 8;
    localparam int POS_W  = 12;
    localparam int CNT_W  = 13;
    localparam int CNT_MAX = (1 << CNT_W) - 1;

    localparam logic [OPC_W-1:0] OP_WRITE   = 3'd0;
    localparam logic [OPC_W-1:0] OP_READ    = 3'd1;
    localparam logic [OPC_W-1:0] OP_PEEK    = 3'd2;
    localparam logic [OPC_W-1:0] OP_DISCARD = 3'd3;
    localparam logic [OPC_W-1:0] OP_CLEAR   = 3'd4;

    typedef struct packed {
        logic [OPC_W-1:0]  opcode;
        logic [BYTE_W-1:0] data_byte;
        logic [POS_W-1:0]  position;
        logic [CNT_W-1:0]  amount;
    } t_obrb_in;

    typedef struct packed {
        logic [BYTE_W-1:0] read_data;
        logic              data_valid;
        logic [CNT_W-1:0]  amount_done;
        logic              overwrote;
        logic [CNT_W-1:0]  occupancy;
    } t_obrb_out;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic resp;
    } t_obrb_cmd;

endpackage

// ===== hw/rtl/obrb_ram.sv =====
module obrb_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [DATA_W-1:0] i_wdata,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/obrb_ctrl.sv =====
module obrb_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    output obrb_pkg::t_obrb_cmd  o_cmd
);

    import obrb_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_RESP = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: n_state = S_RESP;
            S_RESP: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy     = (r_state != S_IDLE);
    assign o_cmd.load = (r_state == S_IDLE) && i_start;
    assign o_cmd.exec = (r_state == S_EXEC);
    assign o_cmd.resp = (r_state == S_RESP);

endmodule

// ===== hw/rtl/obrb_dpath.sv =====
module obrb_dpath #(
    parameter int STORE_DEPTH = obrb_pkg::STORE_DEPTH_DEF,
    parameter int ADDR_W      = $clog2(STORE_DEPTH)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  obrb_pkg::t_obrb_cmd           i_cmd,
    input  obrb_pkg::t_obrb_in            i_item,
    input  logic                          i_cfg_we,
    input  logic [obrb_pkg::CNT_W-1:0]    i_cfg_wdata,
    output logic                          o_ram_we,
    output logic [ADDR_W-1:0]             o_ram_addr,
    output logic [obrb_pkg::BYTE_W-1:0]   o_ram_wdata,
    input  logic [obrb_pkg::BYTE_W-1:0]   i_ram_rdata,
    output obrb_pkg::t_obrb_out           o_result
);

    import obrb_pkg::*;

    // Positions stay below the size, which the 13-bit register caps
    localparam int EFF_DEPTH = (STORE_DEPTH < CNT_MAX) ? STORE_DEPTH : CNT_MAX;
    localparam int PW        = $clog2(EFF_DEPTH);
    localparam int RST_SIZE  = (SIZE_RST_DEF > STORE_DEPTH) ? STORE_DEPTH : SIZE_RST_DEF;

    t_obrb_in          r_item;
    logic [CNT_W-1:0]  r_size;
    logic [PW-1:0]     r_oldest;
    logic [PW-1:0]     r_newest;
    logic [CNT_W-1:0]  r_count;

    logic              r_valid;
    logic [CNT_W-1:0]  r_done;
    logic              r_over;
    logic [CNT_W-1:0]  r_occ;

    logic [CNT_W-1:0]  cfg_size;
    logic [CNT_W-1:0]  disc_n;
    logic [CNT_W-1:0]  step;
    logic [CNT_W:0]    old_sum;
    logic [CNT_W:0]    old_wrap;
    logic [CNT_W:0]    new_sum;
    logic [CNT_W:0]    new_wrap;
    logic [PW-1:0]     old_adv;
    logic [PW-1:0]     new_adv;

    logic [PW-1:0]     n_oldest;
    logic [PW-1:0]     n_newest;
    logic [CNT_W-1:0]  n_count;
    logic [PW-1:0]     acc_ptr;
    logic              acc_we;
    logic              n_valid;
    logic [CNT_W-1:0]  n_done;
    logic              n_over;

    // Clamp a written size into 1..STORE_DEPTH
    always_comb begin
        cfg_size = i_cfg_wdata;
        if (i_cfg_wdata == '0) begin
            cfg_size = CNT_W'(1);
        end else if (32'(i_cfg_wdata) > STORE_DEPTH) begin
            cfg_size = CNT_W'(STORE_DEPTH);
        end
    end

    assign disc_n = (r_item.amount < r_count) ? r_item.amount : r_count;

    always_comb begin
        unique case (r_item.opcode)
            OP_PEEK:    step = {1'b0, r_item.position};
            OP_DISCARD: step = disc_n;
            default:    step = CNT_W'(1);
        endcase
    end

    // Step stays within the count wherever the advanced position is used, so one subtract wraps the sum
    assign old_sum  = (CNT_W+1)'(r_oldest) + {1'b0, step};
    assign old_wrap = (old_sum >= {1'b0, r_size}) ? old_sum - {1'b0, r_size} : old_sum;
    assign old_adv  = PW'(old_wrap);
    assign new_sum  = (CNT_W+1)'(r_newest) + (CNT_W+1)'(1);
    assign new_wrap = (new_sum >= {1'b0, r_size}) ? new_sum - {1'b0, r_size} : new_sum;
    assign new_adv  = PW'(new_wrap);

    always_comb begin
        n_oldest = r_oldest;
        n_newest = r_newest;
        n_count  = r_count;
        acc_ptr  = r_oldest;
        acc_we   = 1'b0;
        n_valid  = 1'b0;
        n_done   = '0;
        n_over   = 1'b0;
        unique case (r_item.opcode)
            OP_WRITE: begin
                acc_we = 1'b1;
                n_done = CNT_W'(1);
                if (r_count == '0) begin
                    // restart at slot zero
                    n_oldest = '0;
                    n_newest = '0;
                    n_count  = CNT_W'(1);
                    acc_ptr  = '0;
                end else if (r_count < r_size) begin
                    n_newest = new_adv;
                    n_count  = r_count + CNT_W'(1);
                    acc_ptr  = new_adv;
                end else begin
                    // full: drop the oldest byte
                    n_oldest = old_adv;
                    n_newest = new_adv;
                    n_over   = 1'b1;
                    acc_ptr  = new_adv;
                end
            end
            OP_READ: begin
                if (r_count != '0) begin
                    n_valid  = 1'b1;
                    n_done   = CNT_W'(1);
                    n_oldest = old_adv;
                    n_count  = r_count - CNT_W'(1);
                end
            end
            OP_PEEK: begin
                acc_ptr = old_adv;
                if ({1'b0, r_item.position} < r_count) begin
                    n_valid = 1'b1;
                    n_done  = CNT_W'(1);
                end
            end
            OP_DISCARD: begin
                n_oldest = old_adv;
                n_count  = r_count - disc_n;
                n_done   = disc_n;
            end
            OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size   <= CNT_W'(RST_SIZE);
            r_oldest <= '0;
            r_newest <= '0;
            r_count  <= '0;
        end else if (i_cfg_we) begin
            r_size   <= cfg_size;
            r_oldest <= '0;
            r_newest <= '0;
            r_count  <= '0;
        end else if (i_cmd.exec) begin
            r_oldest <= n_oldest;
            r_newest <= n_newest;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.exec) begin
            r_valid <= n_valid;
            r_done  <= n_done;
            r_over  <= n_over;
            r_occ   <= n_count;
        end
    end

    assign o_ram_we    = i_cmd.exec && acc_we;
    assign o_ram_addr  = ADDR_W'(acc_ptr);
    assign o_ram_wdata = r_item.data_byte;

    always_comb begin
        o_result.read_data   = r_valid ? i_ram_rdata : '0;
        o_result.data_valid  = r_valid;
        o_result.amount_done = r_done;
        o_result.overwrote   = r_over;
        o_result.occupancy   = r_occ;
    end

endmodule

// ===== hw/rtl/overwriting_byte_ring_buffer_unit.sv =====
// Channel   | Handshake              | Payload                  | Direction
// ----------+------------------------+--------------------------+----------
// command   | start / busy           | i_item (t_obrb_in)       | in
// result    | o_res_strobe           | o_result (t_obrb_out)    | out
// config    | i_cfg_we               | i_cfg_wdata (size)       | in
//
// Every beat passes through accept, execute (pointer update and the one store
// access) and respond. The single store port with its registered read sets the
// respond cycle; busy stays high from the cycle after accept to the strobe.
// The result strobe is high for one cycle, in the respond state that follows
// execute, and is taken at the edge that ends it; no stall.
// Reset (synchronous, active low) empties the buffer and sets the size to
// 4096 or the store depth, whichever is smaller; the store is left as is.
// A size write empties the buffer the same way; write it only while idle.
module overwriting_byte_ring_buffer_unit #(
    parameter int STORE_DEPTH = obrb_pkg::STORE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  obrb_pkg::t_obrb_in          i_item,
    input  logic                        i_cfg_we,
    input  logic [obrb_pkg::CNT_W-1:0]  i_cfg_wdata,
    output logic                        o_res_strobe,
    output obrb_pkg::t_obrb_out         o_result
);

    import obrb_pkg::*;

    localparam int ADDR_W = $clog2(STORE_DEPTH);

    t_obrb_cmd          cmd;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_addr;
    logic [BYTE_W-1:0]  ram_wdata;
    logic [BYTE_W-1:0]  ram_rdata;

    // Sequence each beat through execute and respond
    obrb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    // Pointers, count, size register and the result register
    obrb_dpath #(
        .STORE_DEPTH (STORE_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_ram_we    (ram_we),
        .o_ram_addr  (ram_addr),
        .o_ram_wdata (ram_wdata),
        .i_ram_rdata (ram_rdata),
        .o_result    (o_result)
    );

    // Byte store: one port, read data lands in the respond cycle
    obrb_ram #(
        .DATA_W (BYTE_W),
        .DEPTH  (STORE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign o_res_strobe = cmd.resp;

`ifndef SYNTHESIS
    // An accepted beat always answers with a result strobe
    a_beat_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_res_strobe)
        else $error("accepted beat got no result");

    // A result only appears while a beat is in flight
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |-> busy)
        else $error("result strobe outside a beat");

    // A returned byte counts as exactly one byte done
    a_valid_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && o_result.data_valid) |-> (o_result.amount_done == CNT_W'(1)))
        else $error("valid byte with wrong amount_done");

    // An overwrite leaves the buffer non-empty
    a_over_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && o_result.overwrote) |-> (o_result.occupancy != '0))
        else $error("overwrite reported on an empty buffer");
`endif

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    import obrb_pkg::*;

    // Build the block at its default depth; the predictor follows the same value.
    localparam int DEPTH           = STORE_DEPTH_DEF;
    // Extra opcodes that the block must treat as no-ops.
    localparam logic [OPC_W-1:0] OP_RSVD5 = 3'd5;
    localparam logic [OPC_W-1:0] OP_RSVD6 = 3'd6;
    localparam logic [OPC_W-1:0] OP_RSVD7 = 3'd7;
    // Extra idle cycles after the last result before touching the size register.
    localparam int DRAIN_TAIL      = 4;
    // Quiet cycles tolerated before the watchdog ends the run.
    localparam int STALL_LIMIT     = 1000;
    localparam int RANDOM_PER_SIZE = 28;
    // Size used to run the buffer into overwrite; odd so the wrap is not a power of two.
    localparam int FULL_SIZE       = 301;

    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          start       = 1'b0;
    logic          busy;
    t_obrb_in      i_item      = '0;
    logic          i_cfg_we    = 1'b0;
    logic [CNT_W-1:0] i_cfg_wdata = '0;
    logic          o_res_strobe;
    t_obrb_out     o_result;

    overwriting_byte_ring_buffer_unit #(
        .STORE_DEPTH (DEPTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_item       (i_item),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_res_strobe (o_res_strobe),
        .o_result     (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Ring predictor: own copy of the store, the two positions, the fill
    // count and the size in use.
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] ring_bytes [DEPTH];
    int                head_pos;
    int                tail_pos;
    int                fill_cnt;
    int                ring_size;

    t_obrb_out         ring_expect_q [$];

    int                send_idle_pct = 14;
    int                beats_sent;
    int                results_seen;
    int                overwrites_seen;
    int                misses_seen;
    int                sizes_written;
    int                fault_cnt;

    // Advance a position by n slots, wrapping at the size in use.
    function automatic int ring_advance(int p, int n);
        int s;
        s = p + n;
        while (s >= ring_size) s -= ring_size;
        return s;
    endfunction

    // Clamp a size write into 1..DEPTH and empty the ring.
    function automatic void ring_resize(logic [CNT_W-1:0] value);
        int v;
        v = int'(value);
        if (v == 0) v = 1;
        if (v > DEPTH) v = DEPTH;
        ring_size = v;
        head_pos  = 0;
        tail_pos  = 0;
        fill_cnt  = 0;
    endfunction

    // Apply one beat to the predicted ring and return the result it must produce.
    function automatic t_obrb_out ring_step(t_obrb_in beat);
        t_obrb_out res;
        int        span;
        res = '0;
        case (beat.opcode)
            OP_WRITE: begin
                if (fill_cnt == 0) begin
                    // Restart at slot 0 whenever the ring runs empty.
                    head_pos = 0;
                    tail_pos = 0;
                    fill_cnt = 1;
                end else if (fill_cnt < ring_size) begin
                    tail_pos = ring_advance(tail_pos, 1);
                    fill_cnt++;
                end else begin
                    // Full: drop the oldest byte and keep the count at the size.
                    head_pos = ring_advance(head_pos, 1);
                    tail_pos = ring_advance(tail_pos, 1);
                    res.overwrote = 1'b1;
                end
                ring_bytes[tail_pos] = beat.data_byte;
                res.amount_done = CNT_W'(1);
            end
            OP_READ: begin
                if (fill_cnt != 0) begin
                    res.read_data   = ring_bytes[head_pos];
                    res.data_valid  = 1'b1;
                    res.amount_done = CNT_W'(1);
                    head_pos = ring_advance(head_pos, 1);
                    fill_cnt--;
                end
            end
            OP_PEEK: begin
                if (int'(beat.position) < fill_cnt) begin
                    res.read_data   = ring_bytes[ring_advance(head_pos, int'(beat.position))];
                    res.data_valid  = 1'b1;
                    res.amount_done = CNT_W'(1);
                end
            end
            OP_DISCARD: begin
                // Clamp the drop to what is stored.
                span = (int'(beat.amount) < fill_cnt) ? int'(beat.amount) : fill_cnt;
                head_pos = ring_advance(head_pos, span);
                fill_cnt -= span;
                res.amount_done = span[CNT_W-1:0];
            end
            OP_CLEAR: begin
                fill_cnt = 0;
            end
            default: begin
            end
        endcase
        res.occupancy = fill_cnt[CNT_W-1:0];
        return res;
    endfunction

    function automatic void match_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fault_cnt++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: check each result strobe against the oldest expectation,
    // track size writes, and predict every beat at its accepting edge.
    // All of it samples values from before the edge, so the order of
    // processes within a time step does not matter.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_obrb_out want;
        if (!i_rst_n) begin
            ring_resize(CNT_W'(SIZE_RST_DEF));
            ring_expect_q.delete();
        end else begin
            if (o_res_strobe === 1'b1) begin
                results_seen++;
                if (ring_expect_q.size() == 0) begin
                    $error("result with no beat pending: %p", o_result);
                    fault_cnt++;
                end else begin
                    want = ring_expect_q.pop_front();
                    match_field("read_data",   16'(want.read_data),
                                16'(o_result.read_data));
                    match_field("data_valid",  16'(want.data_valid),
                                16'(o_result.data_valid));
                    match_field("amount_done", 16'(want.amount_done),
                                16'(o_result.amount_done));
                    match_field("overwrote",   16'(want.overwrote),
                                16'(o_result.overwrote));
                    match_field("occupancy",   16'(want.occupancy),
                                16'(o_result.occupancy));
                    if (want.overwrote) overwrites_seen++;
                end
            end
            if (i_cfg_we) ring_resize(i_cfg_wdata);
            if (start && busy === 1'b0) begin
                want = ring_step(i_item);
                if (!want.data_valid && (i_item.opcode == OP_READ || i_item.opcode == OP_PEEK))
                    misses_seen++;
                ring_expect_q.push_back(want);
            end
        end
    end

    // Watchdog: end the run once nothing has moved for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (start && busy === 1'b0) || o_res_strobe === 1'b1 || i_cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_top failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one beat and hold it until accepted. Leave start high on return:
    // the caller either offers the next beat or drops start in this same step.
    task automatic send_beat(input t_obrb_in beat);
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        start  <= 1'b1;
        i_item <= beat;
        do @(posedge i_clk); while (busy !== 1'b0);
        beats_sent++;
    endtask

    // Drop start, wait for every pending result, then let the pipe settle.
    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (ring_expect_q.size() != 0);
        repeat (DRAIN_TAIL) @(posedge i_clk);
    endtask

    // Write the size register while the block is idle.
    task automatic set_size(input int unsigned value);
        wait_drained();
        i_cfg_wdata <= value[CNT_W-1:0];
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sizes_written++;
    endtask

    function automatic t_obrb_in make_beat(logic [OPC_W-1:0] op, int data, int pos, int amt);
        t_obrb_in beat;
        beat.opcode    = op;
        beat.data_byte = data[BYTE_W-1:0];
        beat.position  = pos[POS_W-1:0];
        beat.amount    = amt[CNT_W-1:0];
        return beat;
    endfunction

    // Random beat, mostly writes, reads and in-range peeks so the ring fills
    // and wraps; the unused fields carry random noise.
    function automatic t_obrb_in random_beat();
        t_obrb_in beat;
        int       pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)       beat.opcode = OP_WRITE;
        else if (pick < 63)  beat.opcode = OP_READ;
        else if (pick < 82)  beat.opcode = OP_PEEK;
        else if (pick < 93)  beat.opcode = OP_DISCARD;
        else if (pick < 97)  beat.opcode = OP_CLEAR;
        else begin
            case ($urandom_range(0, 2))
                0:       beat.opcode = OP_RSVD5;
                1:       beat.opcode = OP_RSVD6;
                default: beat.opcode = OP_RSVD7;
            endcase
        end
        beat.data_byte = BYTE_W'($urandom_range(0, 255));
        if (fill_cnt > 0 && $urandom_range(0, 99) < 75)
            beat.position = POS_W'($urandom_range(0, fill_cnt - 1));
        else
            beat.position = POS_W'($urandom_range(0, (1 << POS_W) - 1));
        pick = $urandom_range(0, 99);
        if (pick < 50)       beat.amount = CNT_W'($urandom_range(0, 4));
        else if (pick < 80)  beat.amount = CNT_W'($urandom_range(0, ring_size));
        else                 beat.amount = CNT_W'($urandom_range(0, DEPTH));
        return beat;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Edge cases at the reset size: empty ring, restart at slot 0, peeks in
    // and out of range, clamped discard, clear and the spare opcodes.
    task automatic test_edge_cases();
        send_beat(make_beat(OP_READ,    0,     0,     0));
        send_beat(make_beat(OP_PEEK,    0,     0,     0));
        send_beat(make_beat(OP_DISCARD, 0,     0,     DEPTH));
        send_beat(make_beat(OP_CLEAR,   0,     0,     0));
        send_beat(make_beat(OP_WRITE,   'h00,  0,     0));
        send_beat(make_beat(OP_WRITE,   'hFF,  0,     0));
        send_beat(make_beat(OP_WRITE,   'hA5,  0,     0));
        send_beat(make_beat(OP_PEEK,    0,     0,     0));
        send_beat(make_beat(OP_PEEK,    0,     2,     0));
        send_beat(make_beat(OP_PEEK,    0,     3,     0));
        send_beat(make_beat(OP_PEEK,    0,     4095,  0));
        send_beat(make_beat(OP_READ,    0,     0,     0));
        send_beat(make_beat(OP_DISCARD, 0,     0,     0));
        send_beat(make_beat(OP_DISCARD, 0,     0,     1));
        send_beat(make_beat(OP_RSVD5,   'h3C,  7,     9));
        send_beat(make_beat(OP_RSVD6,   'hC3,  0,     1));
        send_beat(make_beat(OP_RSVD7,   'hFF,  4095,  DEPTH));
        send_beat(make_beat(OP_READ,    0,     0,     0));
        send_beat(make_beat(OP_READ,    0,     0,     0));
        send_beat(make_beat(OP_WRITE,   'h5A,  0,     0));
        send_beat(make_beat(OP_CLEAR,   0,     0,     0));
        send_beat(make_beat(OP_PEEK,    0,     0,     0));
    endtask

    // Fill the buffer at a mid size, overwrite past full, then peek the last
    // slot and discard more than is stored.
    task automatic test_full_store();
        set_size(FULL_SIZE);
        repeat (FULL_SIZE + 3)
            send_beat(make_beat(OP_WRITE, int'($urandom_range(0, 255)), 0, 0));
        send_beat(make_beat(OP_PEEK,    0, FULL_SIZE - 1, 0));
        send_beat(make_beat(OP_PEEK,    0, 0,             0));
        send_beat(make_beat(OP_READ,    0, 0,             0));
        send_beat(make_beat(OP_DISCARD, 0, 0,             DEPTH));
        send_beat(make_beat(OP_READ,    0, 0,             0));
    endtask

    // Size writes below and above the legal range clamp to 1 and to the depth.
    task automatic test_size_clamp();
        set_size(0);
        send_beat(make_beat(OP_WRITE, 'h11, 0, 0));
        send_beat(make_beat(OP_WRITE, 'h22, 0, 0));
        send_beat(make_beat(OP_PEEK,  0,    0, 0));
        send_beat(make_beat(OP_PEEK,  0,    1, 0));
        send_beat(make_beat(OP_READ,  0,    0, 0));
        send_beat(make_beat(OP_READ,  0,    0, 0));
        set_size(CNT_MAX);
        send_beat(make_beat(OP_WRITE,   'h33, 0, 0));
        send_beat(make_beat(OP_WRITE,   'h44, 0, 0));
        send_beat(make_beat(OP_PEEK,    0,    1, 0));
        send_beat(make_beat(OP_DISCARD, 0,    0, 2));
    endtask

    // Random traffic over several sizes, first with light sender gaps, then
    // heavy gaps, then back-to-back; drain now and then mid-stream.
    task automatic test_random_traffic();
        int unsigned sizes [6]      = '{1, 2, 3, 7, 64, DEPTH};
        int          idle_modes [3] = '{14, 81, 0};
        foreach (idle_modes[m]) begin
            send_idle_pct = idle_modes[m];
            foreach (sizes[s]) begin
                set_size(sizes[s]);
                repeat (RANDOM_PER_SIZE) begin
                    if ($urandom_range(0, 63) == 0) wait_drained();
                    send_beat(random_beat());
                end
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_edge_cases();
        test_full_store();
        test_size_clamp();
        test_random_traffic();

        wait_drained();
        $display("Covered %0d beats and %0d results over %0d size writes (sizes 1..%0d).",
                 beats_sent, results_seen, sizes_written, DEPTH);
        $display("Saw %0d overwrites when full and %0d reads or peeks that found nothing.",
                 overwrites_seen, misses_seen);
        if (fault_cnt == 0 && ring_expect_q.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
